### sv/segment_intersection_macros.svh
// assertion helpers for the segment intersection block
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// same-cycle implication, off during reset
`define SGI_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define SGI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset as well
`define SGI_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/sgi_pkg.sv
package sgi_pkg;

   // extra quotient bits above the fraction, enough to see values up to 2.0
   localparam int QUO_GUARD = 2;

   typedef struct packed {
      logic ok;
      logic coll;
      logic ovf_a;
      logic ovf_b;
      logic neg_a;
      logic neg_b;
   } sgi_flags_type;

endpackage

### sv/sgi_divider.sv
module sgi_divider #(
   parameter int MAG_WIDTH  = 66,
   parameter int QUO_WIDTH  = 18,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [MAG_WIDTH-1:0]  in_den,
   input  logic [MAG_WIDTH-1:0]  in_rem_a,
   input  logic [MAG_WIDTH-1:0]  in_rem_b,
   input  logic [QUO_WIDTH-1:0]  in_low_a,
   input  logic [QUO_WIDTH-1:0]  in_low_b,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QUO_WIDTH-1:0]  out_quo_a,
   output logic [QUO_WIDTH-1:0]  out_quo_b,
   output logic [SIDE_WIDTH-1:0] out_side
);

   typedef struct packed {
      logic [MAG_WIDTH-1:0]  den;
      logic [MAG_WIDTH-1:0]  rem_a;
      logic [MAG_WIDTH-1:0]  rem_b;
      logic [QUO_WIDTH-1:0]  low_a;
      logic [QUO_WIDTH-1:0]  low_b;
      logic [QUO_WIDTH-1:0]  quo_a;
      logic [QUO_WIDTH-1:0]  quo_b;
      logic [SIDE_WIDTH-1:0] side;
   } stage_type;

   typedef struct packed {
      logic [MAG_WIDTH-1:0] rem;
      logic                 qbit;
   } step_type;

   // one restoring step: bring in the next numerator bit, subtract if it fits
   function automatic step_type div_step(input logic [MAG_WIDTH-1:0] rem,
                                         input logic nbit,
                                         input logic [MAG_WIDTH-1:0] den);
      logic [MAG_WIDTH:0] trial;
      logic [MAG_WIDTH:0] diff;
      step_type           res;
      trial = {rem, nbit};
      diff = trial - {1'b0, den};
      res.qbit = (trial >= {1'b0, den});
      res.rem = res.qbit ? diff[MAG_WIDTH-1:0] : trial[MAG_WIDTH-1:0];
      return res;
   endfunction

   stage_type             stage_in [QUO_WIDTH];
   stage_type             stage_ff [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]  valid_ff;
   logic [QUO_WIDTH-1:0]  valid_in;
   logic [QUO_WIDTH-1:0]  rdy;

   always_comb begin
      rdy[QUO_WIDTH-1] = !valid_ff[QUO_WIDTH-1] || out_ready;
      for (int i = QUO_WIDTH - 2; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   for (genvar i = 0; i < QUO_WIDTH; i++) begin : g_step
      stage_type src;
      step_type  sa;
      step_type  sb;

      if (i == 0) begin : g_first
         always_comb begin
            src = '0;
            src.den = in_den;
            src.rem_a = in_rem_a;
            src.rem_b = in_rem_b;
            src.low_a = in_low_a;
            src.low_b = in_low_b;
            src.side = in_side;
         end
         assign valid_in[i] = in_valid;
      end else begin : g_next
         assign src = stage_ff[i-1];
         assign valid_in[i] = valid_ff[i-1];
      end

      always_comb begin
         sa = div_step(src.rem_a, src.low_a[QUO_WIDTH-1], src.den);
         sb = div_step(src.rem_b, src.low_b[QUO_WIDTH-1], src.den);
         stage_in[i] = src;
         stage_in[i].rem_a = sa.rem;
         stage_in[i].rem_b = sb.rem;
         stage_in[i].low_a = src.low_a << 1;
         stage_in[i].low_b = src.low_b << 1;
         stage_in[i].quo_a = {src.quo_a[QUO_WIDTH-2:0], sa.qbit};
         stage_in[i].quo_b = {src.quo_b[QUO_WIDTH-2:0], sb.qbit};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign out_quo_a = stage_ff[QUO_WIDTH-1].quo_a;
   assign out_quo_b = stage_ff[QUO_WIDTH-1].quo_b;
   assign out_side  = stage_ff[QUO_WIDTH-1].side;

endmodule

### sv/segment_intersection.sv
// 2-d segment intersection, signed fixed point (COORD_WIDTH bits, FRAC_BITS fraction)
// req channel: valid/ready, one segment pair per transaction (start and direction
//   of each segment). rsp channel: valid/ready, one result per transaction: hit
//   flag and the intersection point, which reads zero on a miss.
// pipeline: one difference stage, one multiply stage, one cross/dot sum stage, one
//   case select stage, FRAC_BITS + 2 restoring divider stages, then range check,
//   point multiply, rounding and saturating add, from req acceptance to rsp_valid.
// throughput: one transaction per cycle unless stalled; each divider stage retires one
//   quotient bit for both parameters, so every stage not held takes a new pair each cycle.
// stalls: each stage carries a valid bit and holds while the stage after it is
//   full and blocked, so a low rsp_ready backs the pipeline up stage by stage;
//   req_ready drops only once every stage holds a transaction. empty stages keep
//   filling while the rsp register waits.
// reset: synchronous, active high; clears all valid bits, so the pipeline comes
//   up empty with req_ready high and rsp_valid low. no startup sequence.
module segment_intersection import sgi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_dir_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y
);

   localparam int W  = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int DW = W + 1;
   localparam int PW = 2 * DW;
   localparam int QW = F + QUO_GUARD;
   localparam int TW = F + 1;
   localparam int MW = W + TW + 1;
   localparam int RW = MW - F;
   localparam int SW = RW + 1;

   typedef struct packed {
      logic signed [W-1:0]  s1x;
      logic signed [W-1:0]  s1y;
      logic signed [W-1:0]  d1x;
      logic signed [W-1:0]  d1y;
      logic signed [W-1:0]  d2x;
      logic signed [W-1:0]  d2y;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
   } st1_type;

   typedef struct packed {
      logic signed [W-1:0]  s1x;
      logic signed [W-1:0]  s1y;
      logic signed [W-1:0]  d1x;
      logic signed [W-1:0]  d1y;
      logic signed [PW-1:0] d1x_d2y;
      logic signed [PW-1:0] d1y_d2x;
      logic signed [PW-1:0] dx_d1y;
      logic signed [PW-1:0] dy_d1x;
      logic signed [PW-1:0] dx_d2y;
      logic signed [PW-1:0] dy_d2x;
      logic signed [PW-1:0] dx_d1x;
      logic signed [PW-1:0] dy_d1y;
      logic signed [PW-1:0] d1x_d1x;
      logic signed [PW-1:0] d1y_d1y;
      logic signed [PW-1:0] d1x_d2x;
      logic signed [PW-1:0] d1y_d2y;
   } st2_type;

   typedef struct packed {
      logic signed [W-1:0]  s1x;
      logic signed [W-1:0]  s1y;
      logic signed [W-1:0]  d1x;
      logic signed [W-1:0]  d1y;
      logic signed [PW-1:0] c12;
      logic signed [PW-1:0] cd1;
      logic signed [PW-1:0] cd2;
      logic signed [PW-1:0] dotd;
      logic signed [PW-1:0] len2;
      logic signed [PW-1:0] dot12;
   } st3_type;

   typedef struct packed {
      logic signed [W-1:0] s1x;
      logic signed [W-1:0] s1y;
      logic signed [W-1:0] d1x;
      logic signed [W-1:0] d1y;
      logic [PW-1:0]       mag_a;
      logic [PW-1:0]       mag_b;
      logic [PW-1:0]       mag_d;
      logic                ok;
      logic                coll;
      logic                neg_a;
      logic                neg_b;
   } st4_type;

   typedef struct packed {
      logic signed [W-1:0] s1x;
      logic signed [W-1:0] s1y;
      logic signed [W-1:0] d1x;
      logic signed [W-1:0] d1y;
      sgi_flags_type       flags;
   } side_type;

   typedef struct packed {
      logic                hit;
      logic [TW-1:0]       t1;
      logic signed [W-1:0] s1x;
      logic signed [W-1:0] s1y;
      logic signed [W-1:0] d1x;
      logic signed [W-1:0] d1y;
   } b1_type;

   typedef struct packed {
      logic                 hit;
      logic signed [W-1:0]  s1x;
      logic signed [W-1:0]  s1y;
      logic signed [MW-1:0] px;
      logic signed [MW-1:0] py;
   } b2_type;

   typedef struct packed {
      logic                 hit;
      logic signed [W-1:0]  s1x;
      logic signed [W-1:0]  s1y;
      logic signed [RW-1:0] qx;
      logic signed [RW-1:0] qy;
   } b3_type;

   localparam logic [QW-1:0]        ONE_Q = QW'(1) << F;
   localparam logic signed [QW+1:0] ONE_S = (QW + 2)'(1) << F;
   localparam logic signed [MW-1:0] BIAS  = (MW'(1) << F) - MW'(1);

   function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      return PW'(a) * PW'(b);
   endfunction

   function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] v);
      return v[PW-1] ? PW'(-v) : PW'(v);
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [W-1:0] res;
      if (v[SW-1:W-1] == '0 || v[SW-1:W-1] == '1) begin
         res = v[W-1:0];
      end else if (v[SW-1]) begin
         res = {1'b1, {(W-1){1'b0}}};
      end else begin
         res = {1'b0, {(W-1){1'b1}}};
      end
      return res;
   endfunction

   st1_type st1_in, st1_ff;
   st2_type st2_in, st2_ff;
   st3_type st3_in, st3_ff;
   st4_type st4_in, st4_ff;
   b1_type  b1_in, b1_ff;
   b2_type  b2_in, b2_ff;
   b3_type  b3_in, b3_ff;
   logic    v1_ff, v2_ff, v3_ff, v4_ff, vb1_ff, vb2_ff, vb3_ff;
   logic    rdy1, rdy2, rdy3, rdy4, rdyb1, rdyb2, rdyb3, rdyo;

   logic signed [PW-1:0] num_a, num_b, den;
   side_type             side_in, side_out;
   logic                 div_in_ready, div_out_valid;
   logic [QW-1:0]        quo_a, quo_b;

   logic                 t1_ok, t2_ok;
   logic signed [QW+1:0] t2_sum;
   logic signed [MW-1:0] tx, ty;

   logic                 rsp_valid_ff, rsp_hit_ff;
   logic signed [W-1:0]  rsp_point_x_ff, rsp_point_y_ff;
   logic                 rsp_hit_in;
   logic signed [W-1:0]  rsp_point_x_in, rsp_point_y_in;

   // stage readiness, back to front
   assign rdyo  = !rsp_valid_ff || rsp_ready;
   assign rdyb3 = !vb3_ff || rdyo;
   assign rdyb2 = !vb2_ff || rdyb3;
   assign rdyb1 = !vb1_ff || rdyb2;
   assign rdy4  = !v4_ff || div_in_ready;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_comb begin
      st1_in.s1x = req_first_start_x;
      st1_in.s1y = req_first_start_y;
      st1_in.d1x = req_first_dir_x;
      st1_in.d1y = req_first_dir_y;
      st1_in.d2x = req_second_dir_x;
      st1_in.d2y = req_second_dir_y;
      st1_in.dx  = DW'(req_second_start_x) - DW'(req_first_start_x);
      st1_in.dy  = DW'(req_second_start_y) - DW'(req_first_start_y);
   end

   always_comb begin
      st2_in.s1x     = st1_ff.s1x;
      st2_in.s1y     = st1_ff.s1y;
      st2_in.d1x     = st1_ff.d1x;
      st2_in.d1y     = st1_ff.d1y;
      st2_in.d1x_d2y = smul(DW'(st1_ff.d1x), DW'(st1_ff.d2y));
      st2_in.d1y_d2x = smul(DW'(st1_ff.d1y), DW'(st1_ff.d2x));
      st2_in.dx_d1y  = smul(st1_ff.dx, DW'(st1_ff.d1y));
      st2_in.dy_d1x  = smul(st1_ff.dy, DW'(st1_ff.d1x));
      st2_in.dx_d2y  = smul(st1_ff.dx, DW'(st1_ff.d2y));
      st2_in.dy_d2x  = smul(st1_ff.dy, DW'(st1_ff.d2x));
      st2_in.dx_d1x  = smul(st1_ff.dx, DW'(st1_ff.d1x));
      st2_in.dy_d1y  = smul(st1_ff.dy, DW'(st1_ff.d1y));
      st2_in.d1x_d1x = smul(DW'(st1_ff.d1x), DW'(st1_ff.d1x));
      st2_in.d1y_d1y = smul(DW'(st1_ff.d1y), DW'(st1_ff.d1y));
      st2_in.d1x_d2x = smul(DW'(st1_ff.d1x), DW'(st1_ff.d2x));
      st2_in.d1y_d2y = smul(DW'(st1_ff.d1y), DW'(st1_ff.d2y));
   end

   always_comb begin
      st3_in.s1x   = st2_ff.s1x;
      st3_in.s1y   = st2_ff.s1y;
      st3_in.d1x   = st2_ff.d1x;
      st3_in.d1y   = st2_ff.d1y;
      st3_in.c12   = st2_ff.d1x_d2y - st2_ff.d1y_d2x;
      st3_in.cd1   = st2_ff.dx_d1y - st2_ff.dy_d1x;
      st3_in.cd2   = st2_ff.dx_d2y - st2_ff.dy_d2x;
      st3_in.dotd  = st2_ff.dx_d1x + st2_ff.dy_d1y;
      st3_in.len2  = st2_ff.d1x_d1x + st2_ff.d1y_d1y;
      st3_in.dot12 = st2_ff.d1x_d2x + st2_ff.d1y_d2y;
   end

   // collinear: project onto the first direction; otherwise cross ratios
   always_comb begin
      st4_in.coll = (st3_ff.c12 == '0) && (st3_ff.cd1 == '0);
      num_a = st4_in.coll ? st3_ff.dotd : st3_ff.cd2;
      num_b = st4_in.coll ? st3_ff.dot12 : st3_ff.cd1;
      den   = st4_in.coll ? st3_ff.len2 : st3_ff.c12;
      st4_in.ok    = st4_in.coll ? (st3_ff.len2 != '0) : (st3_ff.c12 != '0);
      st4_in.mag_a = mag(num_a);
      st4_in.mag_b = mag(num_b);
      st4_in.mag_d = mag(den);
      st4_in.neg_a = num_a[PW-1] ^ den[PW-1];
      st4_in.neg_b = num_b[PW-1] ^ den[PW-1];
      st4_in.s1x   = st3_ff.s1x;
      st4_in.s1y   = st3_ff.s1y;
      st4_in.d1x   = st3_ff.d1x;
      st4_in.d1y   = st3_ff.d1y;
   end

   // quotient of 2^QW or more cannot land in range
   always_comb begin
      side_in.s1x         = st4_ff.s1x;
      side_in.s1y         = st4_ff.s1y;
      side_in.d1x         = st4_ff.d1x;
      side_in.d1y         = st4_ff.d1y;
      side_in.flags.ok    = st4_ff.ok;
      side_in.flags.coll  = st4_ff.coll;
      side_in.flags.neg_a = st4_ff.neg_a;
      side_in.flags.neg_b = st4_ff.neg_b;
      side_in.flags.ovf_a = (st4_ff.mag_a >> QUO_GUARD) >= st4_ff.mag_d;
      side_in.flags.ovf_b = (st4_ff.mag_b >> QUO_GUARD) >= st4_ff.mag_d;
   end

   sgi_divider #(
      .MAG_WIDTH  (PW),
      .QUO_WIDTH  (QW),
      .SIDE_WIDTH ($bits(side_type))
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (div_in_ready),
      .in_den    (st4_ff.mag_d),
      .in_rem_a  (st4_ff.mag_a >> QUO_GUARD),
      .in_rem_b  (st4_ff.mag_b >> QUO_GUARD),
      .in_low_a  ({st4_ff.mag_a[QUO_GUARD-1:0], {F{1'b0}}}),
      .in_low_b  ({st4_ff.mag_b[QUO_GUARD-1:0], {F{1'b0}}}),
      .in_side   (side_in),
      .out_valid (div_out_valid),
      .out_ready (rdyb1),
      .out_quo_a (quo_a),
      .out_quo_b (quo_b),
      .out_side  (side_out)
   );

   // range check; a negative quotient that truncated to zero still counts as zero
   always_comb begin
      t1_ok = !side_out.flags.ovf_a && (!side_out.flags.neg_a || quo_a == '0) &&
              (quo_a <= ONE_Q);
      t2_sum = $signed({2'b00, quo_a}) +
               (side_out.flags.neg_b ? -$signed({2'b00, quo_b}) : $signed({2'b00, quo_b}));
      if (side_out.flags.coll) begin
         t2_ok = !side_out.flags.ovf_b && (t2_sum >= 0) && (t2_sum <= ONE_S);
      end else begin
         t2_ok = !side_out.flags.ovf_b && (!side_out.flags.neg_b || quo_b == '0) &&
                 (quo_b <= ONE_Q);
      end
      b1_in.hit = side_out.flags.ok && t1_ok && t2_ok;
      b1_in.t1  = quo_a[TW-1:0];
      b1_in.s1x = side_out.s1x;
      b1_in.s1y = side_out.s1y;
      b1_in.d1x = side_out.d1x;
      b1_in.d1y = side_out.d1y;
   end

   always_comb begin
      b2_in.hit = b1_ff.hit;
      b2_in.s1x = b1_ff.s1x;
      b2_in.s1y = b1_ff.s1y;
      b2_in.px  = MW'(b1_ff.d1x) * MW'($signed({1'b0, b1_ff.t1}));
      b2_in.py  = MW'(b1_ff.d1y) * MW'($signed({1'b0, b1_ff.t1}));
   end

   // shift out the fraction, truncating toward zero
   always_comb begin
      tx = b2_ff.px + (b2_ff.px[MW-1] ? BIAS : MW'(0));
      ty = b2_ff.py + (b2_ff.py[MW-1] ? BIAS : MW'(0));
      b3_in.hit = b2_ff.hit;
      b3_in.s1x = b2_ff.s1x;
      b3_in.s1y = b2_ff.s1y;
      b3_in.qx  = RW'(tx >>> F);
      b3_in.qy  = RW'(ty >>> F);
   end

   always_comb begin
      rsp_hit_in = b3_ff.hit;
      if (b3_ff.hit) begin
         rsp_point_x_in = sat(SW'(b3_ff.s1x) + SW'(b3_ff.qx));
         rsp_point_y_in = sat(SW'(b3_ff.s1y) + SW'(b3_ff.qy));
      end else begin
         rsp_point_x_in = '0;
         rsp_point_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         vb1_ff       <= 1'b0;
         vb2_ff       <= 1'b0;
         vb3_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdyb1) vb1_ff <= div_out_valid;
         if (rdyb2) vb2_ff <= vb1_ff;
         if (rdyb3) vb3_ff <= vb2_ff;
         if (rdyo) rsp_valid_ff <= vb3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) st1_ff <= st1_in;
      if (rdy2) st2_ff <= st2_in;
      if (rdy3) st3_ff <= st3_in;
      if (rdy4) st4_ff <= st4_in;
      if (rdyb1) b1_ff <= b1_in;
      if (rdyb2) b2_ff <= b2_in;
      if (rdyb3) b3_ff <= b3_in;
      if (rdyo) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_point_x_ff <= rsp_point_x_in;
         rsp_point_y_ff <= rsp_point_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_point_x = rsp_point_x_ff;
   assign rsp_point_y = rsp_point_y_ff;

endmodule

### sv/sgi_checker.sv
`include "segment_intersection_macros.svh"

module sgi_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic signed [COORD_WIDTH-1:0] rsp_point_x,
   input logic signed [COORD_WIDTH-1:0] rsp_point_y
);

   // pipeline comes out of reset empty
   `SGI_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "rsp_valid after reset")

   // a miss carries a zero point
   `SGI_ASSERT_HOLDS(a_miss_zero, rsp_valid && !rsp_hit, rsp_point_x == 0 && rsp_point_y == 0, "nonzero point on miss")

   // when the output register can move, every stage can move
   `SGI_ASSERT_HOLDS(a_ready_flow, !rsp_valid || rsp_ready, req_ready, "req_ready low with free output")

   // a stalled transaction holds
   `SGI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_point_x) && $stable(rsp_point_y), "rsp changed while stalled")

endmodule

bind segment_intersection sgi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sgi_checker (.*);
